>>> design/orsp_pkg.sv
package orsp_pkg;

    localparam logic [7:0] MARK_BYTE  = 8'h02;
    localparam logic [7:0] TEXT_TAG   = 8'h09;
    localparam logic [7:0] SHORT_MARK = 8'hFF;

    localparam logic [7:0] CLASS_LEN = 8'd2;
    localparam logic [7:0] OBIS_LEN  = 8'd6;

    typedef enum logic [2:0] {
        PH_SEARCH = 3'd0,
        PH_CLASS  = 3'd1,
        PH_OBIS   = 3'd2,
        PH_TAG    = 3'd3,
        PH_LEN    = 3'd4,
        PH_VALUE  = 3'd5
    } orsp_phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_frame;
    } orsp_in_word_t;

    typedef struct packed {
        logic [47:0] obis_code;
        logic        obis_short_form;
        logic        is_text;
        logic [63:0] number_value;
        logic [7:0]  text_byte;
        logic        text_byte_valid;
        logic        last_of_record;
        logic        aborted;
    } orsp_result_t;

endpackage

>>> design/orsp_in_stage.sv
module orsp_in_stage
    import orsp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,
    input  logic          s_tlast,
    input  logic          take,
    output logic          word_valid,
    output orsp_in_word_t word
);

    logic          valid_reg;
    logic          valid_next;
    orsp_in_word_t word_reg;

    assign s_tready   = !valid_reg || take;
    assign word_valid = valid_reg;
    assign word       = word_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            word_reg.data_byte    <= s_tdata;
            word_reg.end_of_frame <= s_tlast;
        end
    end

endmodule

>>> design/orsp_parse.sv
module orsp_parse
    import orsp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  orsp_in_word_t word,
    output logic          res_valid,
    output orsp_result_t  res
);

    orsp_phase_t phase_reg, phase_next;
    logic        half_reg, half_next;
    logic [7:0]  count_reg, count_next;
    logic [47:0] obis_reg, obis_next;
    logic [7:0]  tag_reg, tag_next;
    logic [7:0]  len_reg, len_next;
    logic [63:0] acc_reg, acc_next;

    logic [7:0]  b;
    logic [7:0]  count_inc;
    logic [63:0] acc_shift;
    logic        tag_text;
    logic        last_byte;

    assign b         = word.data_byte;
    assign count_inc = count_reg + 8'd1;
    assign acc_shift = {acc_reg[55:0], b};
    assign tag_text  = (tag_reg == TEXT_TAG);
    assign last_byte = (count_inc >= len_reg);

    always_comb
    begin
        phase_next = phase_reg;
        half_next  = half_reg;
        count_next = count_reg;
        obis_next  = obis_reg;
        tag_next   = tag_reg;
        len_next   = len_reg;
        acc_next   = acc_reg;

        res_valid           = 1'b0;
        res.obis_code       = obis_reg;
        res.obis_short_form = (obis_reg[7:0] == SHORT_MARK);
        res.is_text         = tag_text;
        res.number_value    = '0;
        res.text_byte       = '0;
        res.text_byte_valid = 1'b0;
        res.last_of_record  = 1'b1;
        res.aborted         = 1'b0;

        case (phase_reg)
            PH_CLASS:
            begin
                count_next = count_inc;
                if (count_inc >= CLASS_LEN)
                begin
                    count_next = '0;
                    phase_next = PH_OBIS;
                end
            end
            PH_OBIS:
            begin
                obis_next  = {obis_reg[39:0], b};
                count_next = count_inc;
                if (count_inc >= OBIS_LEN)
                begin
                    count_next = '0;
                    phase_next = PH_TAG;
                end
            end
            PH_TAG:
            begin
                tag_next   = b;
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                len_next   = b;
                count_next = '0;
                acc_next   = '0;
                if (b == 8'd0)
                begin
                    res_valid  = 1'b1;
                    phase_next = PH_SEARCH;
                    half_next  = 1'b0;
                end
                else
                begin
                    phase_next = PH_VALUE;
                end
            end
            PH_VALUE:
            begin
                count_next = count_inc;
                if (tag_text)
                begin
                    res_valid           = 1'b1;
                    res.text_byte       = b;
                    res.text_byte_valid = 1'b1;
                    res.last_of_record  = last_byte || word.end_of_frame;
                    res.aborted         = !last_byte && word.end_of_frame;
                end
                else
                begin
                    acc_next           = acc_shift;
                    res_valid          = last_byte;
                    res.number_value   = acc_shift;
                end
                if (last_byte)
                begin
                    phase_next = PH_SEARCH;
                    half_next  = 1'b0;
                end
            end
            default:
            begin
                if (b == MARK_BYTE)
                begin
                    if (half_reg)
                    begin
                        half_next  = 1'b0;
                        count_next = '0;
                        obis_next  = '0;
                        phase_next = PH_CLASS;
                    end
                    else
                    begin
                        half_next = 1'b1;
                    end
                end
                else
                begin
                    half_next = 1'b0;
                end
            end
        endcase

        if (word.end_of_frame)
        begin
            phase_next = PH_SEARCH;
            half_next  = 1'b0;
            count_next = '0;
            obis_next  = '0;
            tag_next   = '0;
            len_next   = '0;
            acc_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEARCH;
            half_reg  <= 1'b0;
            count_reg <= '0;
            obis_reg  <= '0;
            tag_reg   <= '0;
            len_reg   <= '0;
            acc_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            half_reg  <= half_next;
            count_reg <= count_next;
            obis_reg  <= obis_next;
            tag_reg   <= tag_next;
            len_reg   <= len_next;
            acc_reg   <= acc_next;
        end
    end

endmodule

>>> design/orsp_out_stage.sv
module orsp_out_stage
    import orsp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic          res_valid,
    input  orsp_result_t  res,
    output logic          out_free,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata,
    output logic          m_tlast,
    output logic [1:0]    m_tuser
);

    logic         valid_reg;
    logic         valid_next;
    orsp_result_t res_reg;

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tlast  = res_reg.last_of_record;
    assign m_tuser  = {res_reg.aborted, res_reg.is_text};
    assign m_tdata  = {6'd0,
                       res_reg.text_byte_valid,
                       res_reg.text_byte,
                       res_reg.number_value,
                       res_reg.obis_short_form,
                       res_reg.obis_code};

    always_comb
    begin
        valid_next = valid_reg;
        if (out_free)
        begin
            valid_next = step && res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && step && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

>>> design/obis_record_stream_parser_core.sv
// OBIS record parser for a meter response byte stream.
// Input: one byte per word on s_tdata, s_tlast on the final byte of a frame;
// the parser returns to marker search after that byte.
// Output: one word per text character or per complete numeric value, and one
// word for an empty value. m_tlast marks the final word of a record.
// m_tdata, low bit up: obis_code[47:0], obis_short_form[48],
// number_value[112:49], text_byte[120:113], text_byte_valid[121], zeros.
// m_tuser: is_text[0], aborted[1] (frame ended inside a text value).
// m_tvalid rises once a byte has passed the input register and then the result
// register. Throughput: one byte per cycle while m_tready is high, set by the
// single pass of the per-byte state update between the two registers.
// Reset clears the parser state and both valid flags; no words are pending.
// When m_tready is low with a result pending, the result register holds and
// the input register takes one further byte only if it is empty; s_tready
// then drops until the result is taken.
module obis_record_stream_parser_core
    import orsp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // data_byte[7:0]
    input  logic          s_tlast,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata,   // obis_code, obis_short_form, number_value,
                                     // text_byte, text_byte_valid, zero pad
    output logic          m_tlast,
    output logic [1:0]    m_tuser    // is_text, aborted
);

    logic          word_valid;
    orsp_in_word_t word;
    logic          out_free;
    logic          step;
    logic          res_valid;
    orsp_result_t  res;

    assign step = word_valid && out_free;

    orsp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (step),
        .word_valid (word_valid),
        .word       (word)
    );

    orsp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .word      (word),
        .res_valid (res_valid),
        .res       (res)
    );

    orsp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
